/* hw/rtl/trlm_pkg.sv */
`timescale 1ns / 1ps

package trlm_pkg;

    localparam int unsigned WEIGHT_W   = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'h10000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd58982;

    localparam int unsigned COUNT_W = 32;
    localparam int unsigned RATE_W  = 48;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned DQ_W    = RATE_W + 4;   // peak*9 fits here
    localparam int unsigned D10_STEPS = DQ_W / 2;   // radix-4 digits
    localparam int unsigned OUT_LVL_W = 4;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_START,
        OP_MULK,
        OP_KEEP,
        OP_MULW,
        OP_SUM,
        OP_PEAK,
        OP_MULL,
        OP_DIVL
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     mbit;     // multiplier bit, MSB first
        logic     d10;      // one radix-4 step of the divide by ten
        logic     restart;
        logic     up;
    } lane_ctl_t;

    typedef struct packed {
        logic [1:0] q;
        logic [3:0] r;
    } d10_digit_t;

    // x = rem*4 + two dividend bits, x <= 39
    function automatic d10_digit_t d10_step(input logic [5:0] x);
        d10_digit_t d;
        logic [5:0] rr;
        priority if (x >= 6'd30) begin
            d.q = 2'd3;
            rr  = x - 6'd30;
        end else if (x >= 6'd20) begin
            d.q = 2'd2;
            rr  = x - 6'd20;
        end else if (x >= 6'd10) begin
            d.q = 2'd1;
            rr  = x - 6'd10;
        end else begin
            d.q = 2'd0;
            rr  = x;
        end
        d.r = rr[3:0];
        return d;
    endfunction

endpackage

/* hw/rtl/trlm_lane.sv */
`timescale 1ns / 1ps

module trlm_lane
    import trlm_pkg::*;
#(
    parameter int unsigned LEVELS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lane_ctl_t            ctl,
    input  logic [COUNT_W-1:0]   count_i,
    output logic [OUT_LVL_W-1:0] level_o,
    output logic                 peak_nz_o
);

    localparam int unsigned LW = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int unsigned DW = RATE_W + LW;

    logic [COUNT_W-1:0] last_reg, last_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic [RATE_W-1:0]  peak_reg, peak_next;
    logic [COUNT_W-1:0] delta_reg, delta_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [DQ_W-1:0]    dq_reg, dq_next;
    logic [3:0]         rem10_reg, rem10_next;
    logic [DW-1:0]      dsh_reg, dsh_next;
    logic [LW-1:0]      lvl_reg, lvl_next;
    logic               sat_reg, sat_next;

    logic [COUNT_W-1:0] last_eff;
    logic [RATE_W-1:0]  rate_eff, peak_eff, peak_new;
    logic [ACC_W-1:0]   acc_sh;
    logic [ACC_W-1:0]   dsh_ext;
    d10_digit_t         dig;
    logic [LW-1:0]      fin_lvl;

    always_comb begin
        last_eff = ctl.restart ? count_i : last_reg;
        rate_eff = ctl.restart ? '0 : rate_reg;
        peak_eff = ctl.restart ? '0 : peak_reg;
        acc_sh   = {acc_reg[ACC_W-2:0], 1'b0};
        dsh_ext  = ACC_W'(dsh_reg);
        dig      = d10_step({rem10_reg, dq_reg[DQ_W-1 -: 2]});
        peak_new = (rate_reg >= peak_reg) ? rate_reg : dq_reg[RATE_W-1:0];

        last_next  = last_reg;
        rate_next  = rate_reg;
        peak_next  = peak_reg;
        delta_next = delta_reg;
        acc_next   = acc_reg;
        dq_next    = dq_reg;
        rem10_next = rem10_reg;
        dsh_next   = dsh_reg;
        lvl_next   = lvl_reg;
        sat_next   = sat_reg;

        // divide by ten runs in the background from start
        if (ctl.d10) begin
            dq_next    = {dq_reg[DQ_W-3:0], dig.q};
            rem10_next = dig.r;
        end

        unique case (ctl.op)
            OP_START: begin
                if (ctl.up) begin
                    delta_next = count_i - last_eff;
                    last_next  = count_i;
                    rate_next  = rate_eff;
                    peak_next  = peak_eff;
                    acc_next   = '0;
                    dq_next    = (DQ_W'(peak_eff) << 3) + DQ_W'(peak_eff);
                    rem10_next = '0;
                end else begin
                    last_next = last_eff;
                    rate_next = '0;
                    peak_next = '0;
                end
            end
            OP_MULK: acc_next = acc_sh + (ctl.mbit ? ACC_W'(rate_reg) : '0);
            OP_KEEP: begin
                rate_next = acc_reg[ACC_W-1:16];
                acc_next  = '0;
            end
            OP_MULW: acc_next = acc_sh + (ctl.mbit ? ACC_W'(delta_reg) : '0);
            OP_SUM:  rate_next = acc_reg[RATE_W-1:0] + rate_reg;
            OP_PEAK: begin
                peak_next = peak_new;
                sat_next  = rate_reg >= peak_new;
                dsh_next  = DW'(peak_new) << (LW - 1);
                acc_next  = '0;
                lvl_next  = '0;
            end
            OP_MULL: acc_next = acc_sh + (ctl.mbit ? ACC_W'(rate_reg) : '0);
            OP_DIVL: begin
                if (acc_reg >= dsh_ext) begin
                    acc_next = acc_reg - dsh_ext;
                    lvl_next = LW'({lvl_reg, 1'b1});
                end else begin
                    lvl_next = LW'({lvl_reg, 1'b0});
                end
                dsh_next = dsh_reg >> 1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
            rate_reg <= '0;
            peak_reg <= '0;
        end else begin
            last_reg <= last_next;
            rate_reg <= rate_next;
            peak_reg <= peak_next;
        end
    end

    always_ff @(posedge aclk) begin
        delta_reg <= delta_next;
        acc_reg   <= acc_next;
        dq_reg    <= dq_next;
        rem10_reg <= rem10_next;
        dsh_reg   <= dsh_next;
        lvl_reg   <= lvl_next;
        sat_reg   <= sat_next;
    end

    always_comb begin
        priority if (peak_reg == '0) begin
            fin_lvl = '0;
        end else if (sat_reg) begin
            fin_lvl = LW'(LEVELS - 1);
        end else begin
            fin_lvl = lvl_reg;
        end
    end

    assign level_o   = OUT_LVL_W'(fin_lvl);
    assign peak_nz_o = peak_reg != '0;

endmodule

/* hw/rtl/traffic_rate_level_meter_top.sv */
// Traffic rate level meter. Each input transfer carries the running rx/tx
// byte counters, the link-up flag (s_tdata) and a restart command (s_tuser).
// While the link is up each direction's byte delta feeds an exponential
// average with Q1.16 weight average_weight (APB register at address 0), a
// peak follows the average upward and decays by 0.9 per tick, and the level
// reported is floor((LEVELS-1)*rate/peak), saturated at LEVELS-1 and cut to
// 4 bits. Both directions run side by side in two lanes. With the link up,
// an item passes through a bit-serial multiplier that walks 17 weight bits
// in two passes, then a level multiply and divide; a link-down tick goes
// straight to the output. Items are handled one at a time; the result sits
// in an output register, so the next item is accepted while it still waits
// for m_tready.
`timescale 1ns / 1ps

module traffic_rate_level_meter_top
    import trlm_pkg::*;
#(
    parameter int unsigned LEVELS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [31:0] rx_byte_count, [63:32] tx_byte_count,
                                   // [64] link_is_up, [71:65] zero
    input  logic        s_tuser,   // [0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] rx_level, [7:4] tx_level, [8] active,
                                   // [9] redraw, [15:10] zero
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned LW    = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int unsigned CNT_W = 5;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MULK = 9'b000000010,
        S_KEEP = 9'b000000100,
        S_MULW = 9'b000001000,
        S_SUM  = 9'b000010000,
        S_PEAK = 9'b000100000,
        S_MULL = 9'b001000000,
        S_DIVL = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    d10_cnt_reg, d10_cnt_next;
    logic [WEIGHT_W-1:0] mul_sr_reg, mul_sr_next;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                up_reg, up_next;
    logic                was_up_reg, was_up_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [15:0]         m_tdata_reg, m_tdata_next;

    logic [WEIGHT_W-1:0] w_eff, v_eff;
    logic                s_xfer, cfg_wr, out_free, redraw;
    lane_ctl_t           ctl;
    logic [OUT_LVL_W-1:0] rx_level, tx_level;
    logic                rx_peak_nz, tx_peak_nz;

    // ---------------- config register ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(weight_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
        end else if (cfg_wr) begin
            weight_reg <= pwdata[WEIGHT_W-1:0];
        end
    end

    // weight above one counts as one
    assign w_eff = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    assign v_eff = WEIGHT_ONE - w_eff;

    // ---------------- sequencer ----------------
    assign s_tready = state_reg == S_IDLE;
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign redraw   = up_reg ? (!was_up_reg || rx_peak_nz || tx_peak_nz) : was_up_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        d10_cnt_next  = (d10_cnt_reg != '0) ? d10_cnt_reg - 1'b1 : d10_cnt_reg;
        mul_sr_next   = mul_sr_reg;
        up_next       = up_reg;
        was_up_next   = was_up_reg;
        m_tvalid_next = (m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        ctl.op      = OP_IDLE;
        ctl.mbit    = mul_sr_reg[WEIGHT_W-1];
        ctl.d10     = d10_cnt_reg != '0;
        ctl.restart = s_tuser;
        ctl.up      = s_tdata[64];

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    ctl.op  = OP_START;
                    up_next = s_tdata[64];
                    if (s_tdata[64]) begin
                        state_next   = S_MULK;
                        cnt_next     = CNT_W'(WEIGHT_W - 1);
                        mul_sr_next  = v_eff;
                        d10_cnt_next = CNT_W'(D10_STEPS);
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_MULK: begin
                ctl.op      = OP_MULK;
                mul_sr_next = {mul_sr_reg[WEIGHT_W-2:0], 1'b0};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_KEEP;
                end
            end
            S_KEEP: begin
                ctl.op      = OP_KEEP;
                mul_sr_next = w_eff;
                cnt_next    = CNT_W'(WEIGHT_W - 1);
                state_next  = S_MULW;
            end
            S_MULW: begin
                ctl.op      = OP_MULW;
                mul_sr_next = {mul_sr_reg[WEIGHT_W-2:0], 1'b0};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                ctl.op     = OP_SUM;
                state_next = S_PEAK;
            end
            S_PEAK: begin
                ctl.op      = OP_PEAK;
                // LEVELS-1 left-aligned for the MSB-first multiply
                mul_sr_next = WEIGHT_W'(LEVELS - 1) << (WEIGHT_W - LW);
                cnt_next    = CNT_W'(LW - 1);
                state_next  = S_MULL;
            end
            S_MULL: begin
                ctl.op      = OP_MULL;
                mul_sr_next = {mul_sr_reg[WEIGHT_W-2:0], 1'b0};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    cnt_next   = CNT_W'(LW - 1);
                    state_next = S_DIVL;
                end
            end
            S_DIVL: begin
                ctl.op   = OP_DIVL;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, redraw, up_reg, tx_level, rx_level};
                    was_up_next   = up_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            d10_cnt_reg  <= '0;
            up_reg       <= 1'b0;
            was_up_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            d10_cnt_reg  <= d10_cnt_next;
            up_reg       <= up_next;
            was_up_reg   <= was_up_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_sr_reg  <= mul_sr_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- rx / tx lanes ----------------
    trlm_lane #(.LEVELS(LEVELS)) u_rx_lane (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .count_i   (s_tdata[31:0]),
        .level_o   (rx_level),
        .peak_nz_o (rx_peak_nz)
    );

    trlm_lane #(.LEVELS(LEVELS)) u_tx_lane (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .count_i   (s_tdata[63:32]),
        .level_o   (tx_level),
        .peak_nz_o (tx_peak_nz)
    );

endmodule

/* hw/rtl/trlm_checker.sv */
`timescale 1ns / 1ps

module trlm_checker #(
    parameter int unsigned LEVELS = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    localparam logic [3:0] LVL_MAX = (LEVELS > 16) ? 4'd15 : 4'(LEVELS - 1);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // link down gives zero levels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero level with link down");

    // levels stay within range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] <= LVL_MAX && m_tdata[7:4] <= LVL_MAX)
        else $error("level out of range");

    // a new result comes only out of the busy phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a transfer in work");

endmodule

bind traffic_rate_level_meter_top trlm_checker #(.LEVELS(LEVELS)) u_trlm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
